@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define FRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When cond holds, prop must hold at the next clock edge.
`define FRT_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

@@ src/frt_pkg.sv @@
package frt_pkg;

  // Fragment header layout
  localparam int FINAL_BIT = 15;
  localparam int INDEX_W   = 15;
  localparam int WORD_W    = 16;
  localparam int ID_W      = 16;

  // Width of the reported counts
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_RANGE  = 2'd2,
    ST_BADFIN = 2'd3
  } status_t;

  // Per-beat result flags
  typedef struct packed {
    logic    complete;
    status_t status;
  } frt_flags_t;

endpackage

@@ src/frt_update.sv @@
module frt_update #(
  parameter int MAX_FRAGMENTS = 64,
  parameter int MW = MAX_FRAGMENTS,
  parameter int CW = $clog2(MAX_FRAGMENTS + 1)
) (
  input  logic [frt_pkg::ID_W-1:0]   packet_id,
  input  logic [frt_pkg::WORD_W-1:0] fragment_word,
  input  logic [frt_pkg::ID_W-1:0]   cur_id,
  input  logic                       pkt_seen,
  input  logic [MW-1:0]              seen_map,
  input  logic [CW-1:0]              arrived,
  input  logic                       total_known,
  input  logic [CW-1:0]              total_count,
  output logic [frt_pkg::ID_W-1:0]   cur_id_next,
  output logic                       pkt_seen_next,
  output logic [MW-1:0]              seen_map_next,
  output logic [CW-1:0]              arrived_next,
  output logic                       total_known_next,
  output logic [CW-1:0]              total_count_next,
  output frt_pkg::frt_flags_t        flags,
  output logic [CW-1:0]              cnt_out,
  output logic [CW-1:0]              tot_out
);
  import frt_pkg::*;

  localparam int IW = (MAX_FRAGMENTS > 2) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam logic [INDEX_W-1:0] MAX_IDX = INDEX_W'(MAX_FRAGMENTS);

  logic               fin;
  logic [INDEX_W-1:0] idx;
  logic [IW-1:0]      bit_idx;
  logic               in_range;
  logic [MW-1:0]      onehot;
  logic [MW-1:0]      above;
  logic [CW-1:0]      idx_w;
  logic [CW-1:0]      idx_p1;
  logic               new_pkt;
  logic               bad;
  logic               dup;

  // Header decode and bitmap masks
  assign fin      = fragment_word[FINAL_BIT];
  assign idx      = fragment_word[INDEX_W-1:0];
  assign bit_idx  = idx[IW-1:0];
  assign in_range = idx < MAX_IDX;
  assign onehot   = MW'(1) << bit_idx;
  assign above    = ~((onehot - MW'(1)) | onehot);
  assign idx_w    = CW'(bit_idx);
  assign idx_p1   = idx_w + CW'(1);
  assign new_pkt  = !pkt_seen || (packet_id != cur_id);
  assign dup      = seen_map[bit_idx];

  // Consistency check against known total and higher indices seen
  always_comb begin
    if (fin) begin
      bad = (total_known && (total_count != idx_p1)) || (|(seen_map & above));
    end else begin
      bad = total_known && (idx_w >= total_count);
    end
  end

  // Next state and result
  always_comb begin
    cur_id_next      = cur_id;
    pkt_seen_next    = pkt_seen;
    seen_map_next    = seen_map;
    arrived_next     = arrived;
    total_known_next = total_known;
    total_count_next = total_count;
    flags.complete   = 1'b0;
    flags.status     = ST_OK;
    cnt_out          = arrived;
    tot_out          = total_known ? total_count : '0;

    if (!in_range) begin
      flags.status = ST_RANGE;
    end else if (!new_pkt && bad) begin
      flags.status = ST_BADFIN;
    end else begin
      if (new_pkt) begin
        seen_map_next    = onehot;
        arrived_next     = CW'(1);
        total_known_next = 1'b0;
        total_count_next = '0;
        cur_id_next      = packet_id;
        pkt_seen_next    = 1'b1;
      end else if (dup) begin
        flags.status = ST_DUP;
      end else begin
        seen_map_next = seen_map | onehot;
        arrived_next  = arrived + CW'(1);
      end

      if (fin) begin
        total_known_next = 1'b1;
        total_count_next = idx_p1;
      end

      cnt_out = arrived_next;
      tot_out = total_known_next ? total_count_next : '0;

      // All fragments in: report and clear
      if (total_known_next && (arrived_next == total_count_next)) begin
        flags.complete   = 1'b1;
        seen_map_next    = '0;
        arrived_next     = '0;
        total_known_next = 1'b0;
        total_count_next = '0;
      end
    end
  end

endmodule

@@ src/fragment_reassembly_tracker_unit.sv @@
// Channel | Handshake            | Payload
// --------+----------------------+---------------------------------------------------
// in      | in_valid / in_ready  | packet_id, fragment_word
// out     | out_valid / out_ready| complete, status, arrived_count, expected_total
//
// One beat per cycle sustained while out_ready stays high; a header's result passes
// through the input register, then the tracker update into the result register.
// Tracker state is written in the same cycle the result register loads.
// rst is synchronous and clears all control and tracker state.
// A stalled result holds the input register; in_ready drops only when both are full.
`include "assert_macros.svh"

module fragment_reassembly_tracker_unit #(
  parameter int MAX_FRAGMENTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [frt_pkg::ID_W-1:0]      packet_id,
  input  logic [frt_pkg::WORD_W-1:0]    fragment_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          complete,
  output logic [1:0]                    status,
  output logic [frt_pkg::COUNT_W-1:0]   arrived_count,
  output logic [frt_pkg::COUNT_W-1:0]   expected_total
);
  import frt_pkg::*;

  localparam int MW = MAX_FRAGMENTS;
  localparam int CW = $clog2(MAX_FRAGMENTS + 1);
  localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;

  // Input register
  logic              s1_valid;
  logic [ID_W-1:0]   s1_id;
  logic [WORD_W-1:0] s1_word;
  logic              s1_go;

  // Tracker state
  logic [ID_W-1:0] cur_id;
  logic            pkt_seen;
  logic [MW-1:0]   seen_map;
  logic [CW-1:0]   arrived;
  logic            total_known;
  logic [CW-1:0]   total_count;

  logic [ID_W-1:0] cur_id_next;
  logic            pkt_seen_next;
  logic [MW-1:0]   seen_map_next;
  logic [CW-1:0]   arrived_next;
  logic            total_known_next;
  logic [CW-1:0]   total_count_next;
  frt_flags_t      flags;
  logic [CW-1:0]   cnt_out;
  logic [CW-1:0]   tot_out;
  logic [EW-1:0]   cnt_ext;
  logic [EW-1:0]   tot_ext;

  logic            cmpl_go;
  logic            cmpl_out;

  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  // Input beat capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_id   <= packet_id;
      s1_word <= fragment_word;
    end
  end

  frt_update #(
    .MAX_FRAGMENTS(MAX_FRAGMENTS),
    .MW(MW),
    .CW(CW)
  ) u_update (
    .packet_id       (s1_id),
    .fragment_word   (s1_word),
    .cur_id          (cur_id),
    .pkt_seen        (pkt_seen),
    .seen_map        (seen_map),
    .arrived         (arrived),
    .total_known     (total_known),
    .total_count     (total_count),
    .cur_id_next     (cur_id_next),
    .pkt_seen_next   (pkt_seen_next),
    .seen_map_next   (seen_map_next),
    .arrived_next    (arrived_next),
    .total_known_next(total_known_next),
    .total_count_next(total_count_next),
    .flags           (flags),
    .cnt_out         (cnt_out),
    .tot_out         (tot_out)
  );

  // Tracker state update
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_id      <= '0;
      pkt_seen    <= 1'b0;
      seen_map    <= '0;
      arrived     <= '0;
      total_known <= 1'b0;
      total_count <= '0;
    end else if (s1_go) begin
      cur_id      <= cur_id_next;
      pkt_seen    <= pkt_seen_next;
      seen_map    <= seen_map_next;
      arrived     <= arrived_next;
      total_known <= total_known_next;
      total_count <= total_count_next;
    end
  end

  // Counts are reported modulo 128
  assign cnt_ext = EW'(cnt_out);
  assign tot_ext = EW'(tot_out);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      complete       <= flags.complete;
      status         <= flags.status;
      arrived_count  <= cnt_ext[COUNT_W-1:0];
      expected_total <= tot_ext[COUNT_W-1:0];
    end
  end

  // Checks
  assign cmpl_go  = s1_go && flags.complete;
  assign cmpl_out = out_valid && complete;

  `FRT_ASSERT(a_cmpl_status, !cmpl_out || status < ST_RANGE, "error status on completion")
  `FRT_ASSERT(a_cmpl_counts, !cmpl_out || arrived_count == expected_total, "count mismatch")
  `FRT_ASSERT_NEXT(a_cmpl_clear, cmpl_go, arrived == '0 && !total_known && ~|seen_map, "not cleared")
  `FRT_ASSERT(a_count_bound, !total_known || arrived <= total_count, "arrivals exceed total")

endmodule

@@ tb/tb_fragment_reassembly_tracker_unit.sv @@
`timescale 1ns / 1ps

module tb_fragment_reassembly_tracker_unit;
  import frt_pkg::*;

  localparam int FRAG_LIMIT  = 64;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_HEADERS = 650;

  // Directed headers as {packet_id, fragment_word}
  localparam int DIRECTED_COUNT = 23;
  localparam logic [31:0] DIRECTED_HEADERS [DIRECTED_COUNT] = '{
    32'h0000_7FFF,  // index out of range before any packet
    32'h0000_0040,  // first index past the bitmap
    32'h1234_0000,  // first packet starts
    32'h1234_0002,
    32'h1234_0002,  // duplicate
    32'h1234_8001,  // final below a higher seen index
    32'h1234_8004,  // final sets total of 5
    32'h1234_0005,  // non-final past the total
    32'h1234_8005,  // final disagrees with known total
    32'h1234_8004,  // duplicate final, still consistent
    32'h1234_0001,
    32'h1234_0003,  // completes the packet
    32'h1234_0001,  // same id after completion: fresh count
    32'h1234_FFFF,  // out of range with live state
    32'h5678_8000,  // new id, single-fragment packet
    32'hFFFF_803F,  // new id, final at top index
    32'hFFFF_003F,  // duplicate of the top index
    32'h8000_0040,  // out of range under a new id changes nothing
    32'hAAAA_0000,
    32'hAAAA_8000,  // duplicate final that completes
    32'h5555_0001,
    32'h5555_8001,  // duplicate final, not yet complete
    32'h5555_0000   // completes
  };

  // Tracks one packet and queues the result each header should produce
  class fragment_tracker_scoreboard;
    typedef struct packed {
      logic                complete;
      status_t             status;
      logic [COUNT_W-1:0]  arrived_count;
      logic [COUNT_W-1:0]  expected_total;
    } tracker_result_t;

    tracker_result_t expected_results[$];
    int unsigned     mismatches;

    logic [ID_W-1:0]       cur_packet;
    bit                    have_packet;
    logic [FRAG_LIMIT-1:0] seen_bits;
    logic [COUNT_W-1:0]    arrived;
    bit                    total_known;
    logic [COUNT_W-1:0]    total;

    function new();
      mismatches  = 0;
      cur_packet  = '0;
      have_packet = 0;
      seen_bits   = '0;
      arrived     = '0;
      total_known = 0;
      total       = '0;
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction

    function void note_header(logic [ID_W-1:0] id, logic [WORD_W-1:0] word);
      logic                          last_frag;
      logic [INDEX_W-1:0]            idx;
      logic [$clog2(FRAG_LIMIT)-1:0] pos;
      bit                            rejected;
      tracker_result_t               res;
      last_frag          = word[FINAL_BIT];
      idx                = word[INDEX_W-1:0];
      pos                = idx[$clog2(FRAG_LIMIT)-1:0];
      res.complete       = 1'b0;
      res.status         = ST_OK;
      res.arrived_count  = arrived;
      res.expected_total = total_known ? total : '0;

      // range check comes before anything else, no state change
      if (idx >= INDEX_W'(FRAG_LIMIT)) begin
        res.status = ST_RANGE;
        expected_results.push_back(res);
        return;
      end

      if (!have_packet || id != cur_packet) begin
        seen_bits      = '0;
        seen_bits[pos] = 1'b1;
        arrived        = 7'd1;
        total_known    = 0;
        total          = '0;
        cur_packet     = id;
        have_packet    = 1;
      end else begin
        if (last_frag)
          rejected = (total_known && total != 7'(idx + 15'd1)) ||
                     (((seen_bits >> idx) >> 1) != '0);
        else
          rejected = total_known && idx >= INDEX_W'(total);
        if (rejected) begin
          res.status = ST_BADFIN;
          expected_results.push_back(res);
          return;
        end
        if (seen_bits[pos]) begin
          res.status = ST_DUP;
        end else begin
          seen_bits[pos] = 1'b1;
          arrived        = arrived + 7'd1;
        end
      end

      if (last_frag) begin
        total_known = 1;
        total       = 7'(idx + 15'd1);
      end

      res.arrived_count  = arrived;
      res.expected_total = total_known ? total : '0;
      // completion reports the counts, then clears them
      if (total_known && arrived == total) begin
        res.complete = 1'b1;
        seen_bits    = '0;
        arrived      = '0;
        total_known  = 0;
        total        = '0;
      end
      expected_results.push_back(res);
    endfunction

    function void check_result(logic got_complete, logic [1:0] got_status,
                               logic [COUNT_W-1:0] got_count,
                               logic [COUNT_W-1:0] got_total);
      tracker_result_t exp_res;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: complete %0d status %0d",
               got_complete, got_status);
        mismatches++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (got_complete !== exp_res.complete) begin
        $error("complete: expected %0d, got %0d", exp_res.complete, got_complete);
        mismatches++;
      end
      if (got_status !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, got_status);
        mismatches++;
      end
      if (got_count !== exp_res.arrived_count) begin
        $error("arrived_count: expected %0d, got %0d", exp_res.arrived_count, got_count);
        mismatches++;
      end
      if (got_total !== exp_res.expected_total) begin
        $error("expected_total: expected %0d, got %0d", exp_res.expected_total, got_total);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ID_W-1:0]     packet_id = '0;
  logic [WORD_W-1:0]   fragment_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                complete;
  logic [1:0]          status;
  logic [COUNT_W-1:0]  arrived_count;
  logic [COUNT_W-1:0]  expected_total;

  fragment_tracker_scoreboard sb = new();

  bit              steady_flow = 0;
  int              headers_sent = 0;
  logic [ID_W-1:0] last_id = '0;
  int              stall_cycles = 0;

  fragment_reassembly_tracker_unit #(
    .MAX_FRAGMENTS(FRAG_LIMIT)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .packet_id     (packet_id),
    .fragment_word (fragment_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .complete      (complete),
    .status        (status),
    .arrived_count (arrived_count),
    .expected_total(expected_total)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result(complete, status, arrived_count, expected_total);
      out_ready <= steady_flow || ($urandom_range(99) >= 18);
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("fragment_reassembly_tracker_unit test failed");
        $finish;
      end
    end
  end

  // Offer one header, with a random gap first, and hold until accepted
  task automatic send_header(input logic [ID_W-1:0] id, input logic [WORD_W-1:0] word);
    while (!steady_flow && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    packet_id     <= id;
    fragment_word <= word;
    do @(posedge clk); while (!in_ready);
    sb.note_header(id, word);
    last_id = id;
    headers_sent++;
    steady_flow = (headers_sent >= 300 && headers_sent < 400);
  endtask

  // A packet's fragments in random order, with some repeats and early drops
  task automatic send_packet_fragments();
    logic [ID_W-1:0] id;
    int              n;
    int              order [FRAG_LIMIT];
    int              j;
    int              tmp;
    id = ($urandom_range(3) == 0) ? last_id : 16'($urandom);
    if ($urandom_range(19) == 0)
      n = FRAG_LIMIT;
    else if ($urandom_range(9) == 0)
      n = $urandom_range(9, FRAG_LIMIT - 1);
    else
      n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) order[k] = k;
    for (int k = n - 1; k > 0; k--) begin
      j        = $urandom_range(k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < n; k++) begin
      if (k > 0 && $urandom_range(24) == 0) break;
      send_header(id, {order[k] == n - 1, 15'(order[k])});
      if (k < n - 1 && $urandom_range(9) == 0) begin
        j = $urandom_range(k);
        send_header(id, {order[j] == n - 1, 15'(order[j])});
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_HEADERS[i])
      send_header(DIRECTED_HEADERS[i][31:16], DIRECTED_HEADERS[i][15:0]);

    // mostly well-formed packets, some noise
    while (headers_sent < DIRECTED_COUNT + RANDOM_HEADERS) begin
      if ($urandom_range(99) < 80) begin
        send_packet_fragments();
      end else begin
        case ($urandom_range(2))
          0:       send_header(16'($urandom), 16'($urandom));
          1:       send_header(last_id, {1'($urandom), 15'($urandom_range(FRAG_LIMIT - 1))});
          default: send_header(last_id, {1'b1, 15'($urandom_range(FRAG_LIMIT - 1))});
        endcase
      end
    end
    in_valid <= 1'b0;

    // drain, then wait for anything stray
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0)
      $display("fragment_reassembly_tracker_unit test passed");
    else
      $display("fragment_reassembly_tracker_unit test failed");
    $finish;
  end

endmodule
